### src/tgtm_pkg.sv
`timescale 1ns / 1ps
package tgtm_pkg;
   typedef enum logic [1:0] {
      G_IDLE  = 2'd0,
      G_HOLD  = 2'd1,
      G_PINCH = 2'd2,
      G_SWIPE = 2'd3
   } gesture_kind_type;

   localparam logic [1:0] K_THRESH = 2'd0;
   localparam logic [1:0] K_REPEAT = 2'd1;
   localparam logic [1:0] K_END    = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_DISCARD  = 2'd1;
   localparam logic [1:0] ST_MISMATCH = 2'd2;
   localparam logic [1:0] ST_IGNORED  = 2'd3;

   localparam logic [3:0] EV_HOLD_BEGIN   = 4'd0;
   localparam logic [3:0] EV_HOLD_END     = 4'd1;
   localparam logic [3:0] EV_PINCH_BEGIN  = 4'd2;
   localparam logic [3:0] EV_PINCH_UPDATE = 4'd3;
   localparam logic [3:0] EV_PINCH_END    = 4'd4;
   localparam logic [3:0] EV_SWIPE_BEGIN  = 4'd5;
   localparam logic [3:0] EV_SWIPE_UPDATE = 4'd6;
   localparam logic [3:0] EV_SWIPE_END    = 4'd7;

   localparam logic [1:0] CSR_ADDR  = 2'd0;
   localparam logic [1:0] CSR_WORD  = 2'd1;
   localparam logic [1:0] CSR_COUNT = 2'd2;

   localparam int WORD_W = 58;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PREP,
      S_DIV,
      S_REQ,
      S_SCAN,
      S_WAIT,
      S_DONE,
      S_OUT
   } state_type;

   typedef struct packed {
      logic        start;
      logic [1:0]  gesture;
      logic [2:0]  fingers;
      logic [1:0]  kind;
      logic [31:0] dur;
      logic [2:0]  dir;
      logic [23:0] amt;
   } search_req_type;

   typedef struct packed {
      logic        done;
      logic        hit;
   } search_rsp_type;
endpackage

### src/tgtm_ram.sv
`timescale 1ns / 1ps
module tgtm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### src/tgtm_search.sv
`timescale 1ns / 1ps
module tgtm_search
   import tgtm_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [3:0]            wr_addr,
   input  logic [WORD_W-1:0]     wr_data,
   input  logic [4:0]            count,
   input  search_req_type        req,
   output search_rsp_type        rsp,
   output logic [3:0]            slot
);
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic [AW-1:0] rd_addr;
   logic [WORD_W-1:0] word;
   logic [CW:0] idx_ff, idx_in;
   logic busy_ff, busy_in, vld_ff, vld_in;
   logic [CW:0] limit;
   logic match;
   logic [3:0] slot_ff, slot_in;
   logic ram_we;

   assign ram_we = wr_en && ({5'd0, wr_addr} < 9'(TABLE_DEPTH));
   assign limit = (9'(count) > 9'(TABLE_DEPTH)) ? (CW+1)'(TABLE_DEPTH) : (CW+1)'(count);
   assign rd_addr = idx_ff[AW-1:0];

   tgtm_ram #(.WIDTH(WORD_W), .DEPTH(1 << AW)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (AW'(wr_addr)),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (word)
   );

   always_comb begin
      logic [15:0] tmin, tmax, thr;
      logic [2:0] td;
      logic thr_ok;
      tmin = word[25:10];
      tmax = word[41:26];
      thr = word[57:42];
      td = word[9:7];
      if (thr == 16'd0 || req.gesture == G_HOLD) begin
         thr_ok = 1'b1;
      end else if (req.gesture == G_PINCH && thr < 16'd256) begin
         thr_ok = req.amt <= {8'd0, thr};
      end else begin
         thr_ok = req.amt >= {8'd0, thr};
      end
      match = (word[1:0] == req.gesture) && (word[4:2] == req.fingers) &&
              (word[6:5] == req.kind) &&
              (req.dir == 3'd0 || td == 3'd0 || td == req.dir) &&
              (tmin == 16'd0 || {16'd0, tmin} <= req.dur) &&
              (tmax == 16'd0 || {16'd0, tmax} >= req.dur) && thr_ok;
   end

   always_comb begin
      idx_in = idx_ff;
      busy_in = busy_ff;
      vld_in = 1'b0;
      slot_in = slot_ff;
      rsp = '0;
      if (req.start) begin
         idx_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (vld_ff && match) begin
            busy_in = 1'b0;
            rsp.done = 1'b1;
            rsp.hit = 1'b1;
            slot_in = 4'(idx_ff - 1'b1);
         end else if (idx_ff >= limit) begin
            busy_in = 1'b0;
            rsp.done = 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
            vld_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         vld_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         vld_ff <= vld_in;
      end
      idx_ff <= idx_in;
      slot_ff <= slot_in;
   end

   assign slot = slot_in;
endmodule

### src/touch_gesture_trigger_matcher_unit.sv
`timescale 1ns / 1ps
// Begins, cancels, mismatches and ignored events are answered without a table
// search; an update or end searches the first n table slots, n the slot count
// clamped to TABLE_DEPTH, and a threshold miss on an update is searched again.
// A pinch repeat search first runs the serial ratio divider.
// One event is in flight at a time; req_tready is low until rsp is taken.
// Synchronous active-high reset returns the gesture state to idle.
module touch_gesture_trigger_matcher_unit
   import tgtm_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // event_kind, cancelled, finger_count, timestamp_ms, delta_x, delta_y,
   // pinch_scale
   input  logic [87:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // fired, trigger_slot, fire_kind, direction, amount, duration_ms,
   // status
   output logic [71:0]  rsp_tdata,
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_index,
   input  logic [57:0]  csr_wr_data
);
   state_type state_ff, state_in;
   logic [87:0] in_ff, in_in;
   logic [1:0] gest_ff, gest_in;
   logic [31:0] start_ff, start_in;
   logic signed [23:0] sx_ff, sx_in, sy_ff, sy_in, fx_ff, fx_in, fy_ff, fy_in;
   logic [15:0] cur_ff, cur_in, ref_ff, ref_in;
   logic [3:0] waddr_ff;
   logic [4:0] count_ff;
   logic [71:0] out_ff, out_in;
   logic [1:0] kind_ff, kind_in;
   logic [2:0] dir_ff, dir_in;
   logic [23:0] amt_ff, amt_in;
   logic [23:0] quo_ff, quo_in;
   logic [24:0] rem_ff, rem_in;
   logic [4:0] cnt_ff, cnt_in;
   search_req_type sreq;
   search_rsp_type srsp;
   logic [3:0] slot;

   logic [3:0] ev;
   logic canc;
   logic [2:0] fing;
   logic [31:0] ts;
   logic signed [15:0] ddx, ddy;
   logic [15:0] scl;
   logic [1:0] g;
   logic [1:0] step;
   logic [31:0] dur;

   assign ev = in_ff[3:0];
   assign canc = in_ff[4];
   assign fing = in_ff[7:5];
   assign ts = in_ff[39:8];
   assign ddx = in_ff[55:40];
   assign ddy = in_ff[71:56];
   assign scl = in_ff[87:72];
   assign dur = ts - start_ff;

   always_comb begin
      unique case (ev)
         EV_HOLD_BEGIN:   begin g = G_HOLD;  step = 2'd0; end
         EV_HOLD_END:     begin g = G_HOLD;  step = 2'd2; end
         EV_PINCH_BEGIN:  begin g = G_PINCH; step = 2'd0; end
         EV_PINCH_UPDATE: begin g = G_PINCH; step = 2'd1; end
         EV_PINCH_END:    begin g = G_PINCH; step = 2'd2; end
         EV_SWIPE_BEGIN:  begin g = G_SWIPE; step = 2'd0; end
         EV_SWIPE_UPDATE: begin g = G_SWIPE; step = 2'd1; end
         EV_SWIPE_END:    begin g = G_SWIPE; step = 2'd2; end
         default:         begin g = G_IDLE;  step = 2'd3; end
      endcase
   end

   function automatic logic signed [23:0] sat_add(logic signed [23:0] a,
                                                   logic signed [15:0] b);
      logic signed [24:0] s;
      s = 25'(a) + 25'(b);
      if (s > 25'sd8388607) return 24'sh7FFFFF;
      if (s < -25'sd8388608) return 24'sh800000;
      return s[23:0];
   endfunction

   function automatic logic [26:0] describe(logic signed [24:0] x,
                                            logic signed [24:0] y);
      logic signed [24:0] dx, dy;
      logic [24:0] ax, ay, a;
      logic [2:0] d;
      dx = x;
      dy = y;
      ax = dx[24] ? 25'(-dx) : 25'(dx);
      ay = dy[24] ? 25'(-dy) : 25'(dy);
      if (ax > ay) begin
         d = (dx > 0) ? 3'd4 : 3'd3;
         a = ax;
      end else begin
         d = (dy > 0) ? 3'd2 : 3'd1;
         a = ay;
      end
      return {d, a[24] ? 24'hFFFFFF : a[23:0]};
   endfunction

   tgtm_search #(.TABLE_DEPTH(TABLE_DEPTH)) u_search (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (csr_wr_en && csr_index == CSR_WORD),
      .wr_addr (waddr_ff),
      .wr_data (csr_wr_data),
      .count   (count_ff),
      .req     (sreq),
      .rsp     (srsp),
      .slot    (slot)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata = out_ff;

   always_comb begin
      logic [26:0] dd;
      logic [24:0] diff;
      state_in = state_ff;
      in_in = in_ff;
      gest_in = gest_ff; start_in = start_ff;
      sx_in = sx_ff; sy_in = sy_ff; fx_in = fx_ff; fy_in = fy_ff;
      cur_in = cur_ff; ref_in = ref_ff;
      out_in = out_ff;
      kind_in = kind_ff; dir_in = dir_ff; amt_in = amt_ff;
      quo_in = quo_ff; rem_in = rem_ff; cnt_in = cnt_ff;
      sreq = '0;
      sreq.gesture = g; sreq.fingers = fing; sreq.kind = kind_ff;
      sreq.dur = dur; sreq.dir = dir_ff; sreq.amt = amt_ff;
      dd = '0; diff = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               in_in = req_tdata;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            out_in = '0;
            state_in = S_OUT;
            if (step == 2'd3) begin
               out_in[67:66] = ST_IGNORED;
            end else if (step == 2'd2 && canc) begin
               gest_in = G_IDLE; start_in = '0;
               sx_in = '0; sy_in = '0; fx_in = '0; fy_in = '0;
               cur_in = 16'd256; ref_in = 16'd256;
            end else if (step == 2'd0) begin
               if (gest_ff != G_IDLE || start_ff != 32'd0) out_in[67:66] = ST_DISCARD;
               gest_in = g; start_in = ts;
               sx_in = '0; sy_in = '0; fx_in = '0; fy_in = '0;
               cur_in = 16'd256; ref_in = 16'd256;
            end else if (g != gest_ff) begin
               out_in[67:66] = ST_MISMATCH;
            end else begin
               state_in = S_REQ;
               if (g == G_SWIPE && step == 2'd1) begin
                  sx_in = sat_add(sx_ff, ddx);
                  sy_in = sat_add(sy_ff, ddy);
                  dd = describe(25'(sx_in), 25'(sy_in));
                  dir_in = dd[26:24]; amt_in = dd[23:0];
                  if (fx_ff == 0 || fy_ff == 0) begin
                     kind_in = K_THRESH;
                  end else begin
                     kind_in = K_REPEAT;
                     dd = describe(25'(sx_in) - 25'(fx_ff), 25'(sy_in) - 25'(fy_ff));
                     dir_in = dd[26:24]; amt_in = dd[23:0];
                  end
               end else if (g == G_PINCH && step == 2'd1) begin
                  cur_in = scl;
                  dir_in = 3'd0;
                  if (ref_ff == 16'd256) begin
                     kind_in = K_THRESH;
                     amt_in = {8'd0, scl};
                  end else begin
                     kind_in = K_REPEAT;
                     state_in = S_DIV;
                     quo_in = {scl, 8'd0}; rem_in = '0; cnt_in = '0;
                  end
               end else begin
                  kind_in = K_END;
                  if (g == G_SWIPE) begin
                     dd = describe(25'(sx_ff), 25'(sy_ff));
                     dir_in = dd[26:24]; amt_in = dd[23:0];
                  end else begin
                     dir_in = 3'd0;
                     amt_in = (g == G_PINCH) ? {8'd0, cur_ff} : 24'd0;
                  end
               end
            end
         end
         S_DIV: begin
            if (ref_ff == 16'd0) begin
               amt_in = 24'hFFFFFF;
               state_in = S_REQ;
            end else begin
               diff = {rem_ff[23:0], quo_ff[23]} - {9'd0, ref_ff};
               if (!diff[24]) begin
                  rem_in = diff;
                  quo_in = {quo_ff[22:0], 1'b1};
               end else begin
                  rem_in = {rem_ff[23:0], quo_ff[23]};
                  quo_in = {quo_ff[22:0], 1'b0};
               end
               cnt_in = cnt_ff + 5'd1;
               if (cnt_ff == 5'd23) begin
                  amt_in = quo_in;
                  state_in = S_REQ;
               end
            end
         end
         S_REQ: begin
            sreq.start = 1'b1;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (srsp.done) begin
               if (!srsp.hit && kind_ff == K_THRESH && step == 2'd1) begin
                  kind_in = K_REPEAT;
                  if (g == G_SWIPE) begin
                     dd = describe(25'(sx_ff) - 25'(fx_ff), 25'(sy_ff) - 25'(fy_ff));
                     dir_in = dd[26:24]; amt_in = dd[23:0];
                     state_in = S_REQ;
                  end else begin
                     quo_in = {cur_ff, 8'd0}; rem_in = '0; cnt_in = '0;
                     state_in = S_DIV;
                  end
               end else begin
                  out_in = {4'd0, ST_OK, dur, amt_ff, dir_ff, kind_ff,
                            srsp.hit ? slot : 4'd0, srsp.hit};
                  state_in = S_OUT;
                  if (step == 2'd2) begin
                     gest_in = G_IDLE; start_in = '0;
                     sx_in = '0; sy_in = '0; fx_in = '0; fy_in = '0;
                     cur_in = 16'd256; ref_in = 16'd256;
                  end else if (srsp.hit) begin
                     if (g == G_SWIPE) begin
                        fx_in = sx_ff; fy_in = sy_ff;
                     end else begin
                        ref_in = cur_ff;
                     end
                  end
               end
            end
         end
         S_OUT: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         gest_ff <= G_IDLE; start_ff <= '0;
         sx_ff <= '0; sy_ff <= '0; fx_ff <= '0; fy_ff <= '0;
         cur_ff <= 16'd256; ref_ff <= 16'd256;
         waddr_ff <= '0; count_ff <= '0;
      end else begin
         state_ff <= state_in;
         gest_ff <= gest_in; start_ff <= start_in;
         sx_ff <= sx_in; sy_ff <= sy_in; fx_ff <= fx_in; fy_ff <= fy_in;
         cur_ff <= cur_in; ref_ff <= ref_in;
         if (csr_wr_en && csr_index == CSR_ADDR) waddr_ff <= csr_wr_data[3:0];
         if (csr_wr_en && csr_index == CSR_COUNT) count_ff <= csr_wr_data[4:0];
      end
      in_ff <= in_in; out_ff <= out_in;
      kind_ff <= kind_in; dir_ff <= dir_in; amt_ff <= amt_in;
      quo_ff <= quo_in; rem_ff <= rem_in; cnt_ff <= cnt_in;
   end

   a_ready_out: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("ready while result pending");
   a_accept_prep: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> state_ff == S_PREP)
      else $error("accepted item not started");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
endmodule

### verif/tb.sv
`timescale 1ns / 1ps
module tb;
   import tgtm_pkg::*;

   localparam logic [2:0] DIR_NONE  = 3'd0;
   localparam logic [2:0] DIR_UP    = 3'd1;
   localparam logic [2:0] DIR_DOWN  = 3'd2;
   localparam logic [2:0] DIR_LEFT  = 3'd3;
   localparam logic [2:0] DIR_RIGHT = 3'd4;
   localparam logic [3:0] EV_OTHER  = 4'd8;
   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam int DEPTH = 16;
   localparam int SETTLE = 200;

   typedef struct packed {
      logic [15:0]        scale;
      logic signed [15:0] dy;
      logic signed [15:0] dx;
      logic [31:0]        ts;
      logic [2:0]         fingers;
      logic               canc;
      logic [3:0]         kind;
   } gesture_event_t;

   typedef struct packed {
      logic [3:0]  pad;
      logic [1:0]  status;
      logic [31:0] dur;
      logic [23:0] amt;
      logic [2:0]  dir;
      logic [1:0]  fk;
      logic [3:0]  slot;
      logic        fired;
   } match_report_t;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [87:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [71:0]  rsp_tdata;
   logic         csr_wr_en = 1'b0;
   logic [1:0]   csr_index = CSR_ADDR;
   logic [57:0]  csr_wr_data = '0;

   touch_gesture_trigger_matcher_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   gesture_event_t pending_events[$];
   match_report_t  expected_reports[$];
   int errors = 0;
   int req_accepts = 0, req_seen = 0, req_gap = 0;
   int rsp_count = 0, rsp_seen = 0, rsp_wait = 0, fired_count = 0;
   bit req_quiet = 0, rsp_quiet = 0, held_once = 0;

   // Gesture tracker state mirrored from the block.
   gesture_kind_type m_active;
   logic [31:0] m_start;
   int m_sx, m_sy, m_fx, m_fy;
   int unsigned m_cur, m_ref;
   logic [57:0] m_table[DEPTH];
   logic [3:0] m_addr;
   logic [4:0] m_count;

   function automatic void go_idle();
      m_active = G_IDLE;
      m_start = 0;
      m_sx = 0; m_sy = 0; m_fx = 0; m_fy = 0;
      m_cur = 256; m_ref = 256;
   endfunction

   function automatic int sat24(int a, int b);
      int s;
      s = a + b;
      if (s > 8388607) return 8388607;
      if (s < -8388608) return -8388608;
      return s;
   endfunction

   function automatic void swipe_vector(int ox, int oy, output logic [2:0] dir,
                                        output int unsigned amt);
      int dx, dy;
      int unsigned ax, ay, a;
      dx = m_sx - ox;
      dy = m_sy - oy;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      if (ax > ay) begin
         dir = dx > 0 ? DIR_RIGHT : DIR_LEFT;
         a = ax;
      end else begin
         dir = dy > 0 ? DIR_DOWN : DIR_UP;
         a = ay;
      end
      amt = a > 32'hFFFFFF ? 32'hFFFFFF : a;
   endfunction

   function automatic int find_slot(gesture_kind_type g, logic [2:0] fingers, logic [1:0] kind,
                                    logic [31:0] dur, logic [2:0] dir, int unsigned amt);
      int n;
      logic [57:0] w;
      logic [15:0] tmin, tmax, thr;
      bit pass;
      n = m_count > DEPTH ? DEPTH : m_count;
      for (int i = 0; i < n; i++) begin
         w = m_table[i];
         tmin = w[25:10];
         tmax = w[41:26];
         thr = w[57:42];
         if (thr == 0) pass = 1;
         else if (g == G_SWIPE) pass = amt >= thr;
         else if (g == G_PINCH) pass = thr < 256 ? amt <= thr : amt >= thr;
         else pass = 1;
         if (w[1:0] == g && w[4:2] == fingers && w[6:5] == kind &&
             (dir == DIR_NONE || w[9:7] == DIR_NONE || w[9:7] == dir) &&
             (tmin == 0 || tmin <= dur) && (tmax == 0 || tmax >= dur) && pass)
            return i;
      end
      return -1;
   endfunction

   function automatic match_report_t predict_match(gesture_event_t e);
      match_report_t r;
      gesture_kind_type g;
      int step, m;
      logic [31:0] dur;
      logic [2:0] dir;
      int unsigned amt;
      logic [1:0] fk;
      r = '0;
      m = -1;
      dir = DIR_NONE;
      amt = 0;
      fk = K_THRESH;
      if (e.kind > EV_SWIPE_END) begin
         r.status = ST_IGNORED;
         return r;
      end
      if (e.kind <= EV_HOLD_END) begin
         g = G_HOLD;
         step = e.kind == EV_HOLD_BEGIN ? 0 : 2;
      end else if (e.kind <= EV_PINCH_END) begin
         g = G_PINCH;
         step = e.kind - EV_PINCH_BEGIN;
      end else begin
         g = G_SWIPE;
         step = e.kind - EV_SWIPE_BEGIN;
      end
      if (step == 2 && e.canc) begin
         go_idle();
         return r;
      end
      if (step == 0) begin
         if (m_active != G_IDLE || m_start != 0) r.status = ST_DISCARD;
         go_idle();
         m_start = e.ts;
         m_active = g;
         return r;
      end
      if (g != m_active) begin
         r.status = ST_MISMATCH;
         return r;
      end
      dur = e.ts - m_start;
      if (g == G_SWIPE && step == 1) begin
         m_sx = sat24(m_sx, e.dx);
         m_sy = sat24(m_sy, e.dy);
         swipe_vector(0, 0, dir, amt);
         if (m_fx == 0 || m_fy == 0) begin
            fk = K_THRESH;
            m = find_slot(g, e.fingers, fk, dur, dir, amt);
         end
         if (m < 0) begin
            swipe_vector(m_fx, m_fy, dir, amt);
            fk = K_REPEAT;
            m = find_slot(g, e.fingers, fk, dur, dir, amt);
         end
         if (m >= 0) begin
            m_fx = m_sx;
            m_fy = m_sy;
         end
      end else if (g == G_PINCH && step == 1) begin
         m_cur = e.scale;
         if (m_ref == 256) begin
            fk = K_THRESH;
            amt = m_cur;
            m = find_slot(g, e.fingers, fk, dur, DIR_NONE, amt);
         end
         if (m < 0) begin
            fk = K_REPEAT;
            amt = m_ref == 0 ? 32'hFFFFFF : (m_cur << 8) / m_ref;
            m = find_slot(g, e.fingers, fk, dur, DIR_NONE, amt);
         end
         if (m >= 0) m_ref = m_cur;
      end else begin
         fk = K_END;
         if (g == G_SWIPE) swipe_vector(0, 0, dir, amt);
         else if (g == G_PINCH) amt = m_cur;
         m = find_slot(g, e.fingers, fk, dur, dir, amt);
         go_idle();
      end
      if (m >= 0) begin
         r.fired = 1'b1;
         r.slot = m[3:0];
      end
      r.fk = fk;
      r.dir = dir;
      r.amt = amt[23:0];
      r.dur = dur;
      return r;
   endfunction

   function automatic void check_field(string name, longint unsigned want, longint unsigned got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   function automatic int draw_gap(inout bit quiet);
      if ($urandom_range(0, 40) == 0) quiet = !quiet;
      return quiet ? 0 : $urandom_range(0, 18);
   endfunction

   initial begin
      forever #5 clock = !clock;
   end

   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

   always @(posedge clock) begin
      match_report_t want, got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_reports.push_back(predict_match(req_tdata));
            req_accepts++;
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            got = rsp_tdata;
            if (got.fired) fired_count++;
            if (expected_reports.size() == 0) begin
               $display("%0t: unexpected transfer, actual %h", $time, rsp_tdata);
               errors++;
            end else begin
               want = expected_reports.pop_front();
               check_field("fired", want.fired, got.fired);
               check_field("trigger_slot", want.slot, got.slot);
               check_field("fire_kind", want.fk, got.fk);
               check_field("direction", want.dir, got.dir);
               check_field("amount", want.amt, got.amt);
               check_field("duration_ms", want.dur, got.dur);
               check_field("status", want.status, got.status);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (!reset && !(req_tvalid && req_seen == req_accepts)) begin
         req_seen = req_accepts;
         if (req_gap > 0) begin
            req_tvalid <= 1'b0;
            req_gap--;
         end else if (pending_events.size() != 0) begin
            req_tdata <= pending_events.pop_front();
            req_tvalid <= 1'b1;
            req_gap = draw_gap(req_quiet);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // The receiver stalls for a long stretch once, so the block backs up.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_seen != rsp_count) begin
            rsp_seen = rsp_count;
            rsp_wait = draw_gap(rsp_quiet);
            if (rsp_count >= 300 && !held_once) begin
               rsp_wait = 600;
               held_once = 1;
            end
         end
         if (rsp_wait > 0) begin
            rsp_tready <= 1'b0;
            rsp_wait--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic csr_write(logic [1:0] index, logic [57:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wr_data <= data;
      case (index)
         CSR_ADDR: m_addr = data[3:0];
         CSR_WORD: m_table[m_addr] = data;
         CSR_COUNT: m_count = data[4:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [57:0] make_trigger(int finger_span);
      logic [57:0] w;
      logic [1:0] g;
      g = $urandom_range(0, 3);
      w = '0;
      w[1:0] = g;
      w[4:2] = $urandom_range(0, 5) == 0 ? $urandom_range(0, 7) : $urandom_range(0, finger_span);
      w[6:5] = $urandom_range(0, 6) == 0 ? 2'd3 : $urandom_range(0, 2);
      w[9:7] = $urandom_range(0, 2) == 0 ? $urandom_range(0, 7) : $urandom_range(0, 4);
      case ($urandom_range(0, 3))
         0: w[25:10] = $urandom_range(0, 400);
         1: w[25:10] = $urandom_range(0, 16'hFFFF);
         default: w[25:10] = 0;
      endcase
      case ($urandom_range(0, 3))
         0: w[41:26] = $urandom_range(100, 3000);
         1: w[41:26] = $urandom_range(0, 16'hFFFF);
         default: w[41:26] = 0;
      endcase
      case ($urandom_range(0, 3))
         0: w[57:42] = 0;
         1: w[57:42] = $urandom_range(1, 255);
         2: w[57:42] = $urandom_range(256, 2048);
         default: w[57:42] = $urandom_range(0, 16'hFFFF);
      endcase
      return w;
   endfunction

   task automatic load_table(int finger_span, logic [4:0] count);
      for (int i = 0; i < DEPTH; i++) begin
         csr_write(CSR_ADDR, i);
         csr_write(CSR_WORD, make_trigger(finger_span));
      end
      csr_write(CSR_COUNT, count);
      csr_write(CSR_SPARE, {$urandom, $urandom});
   endtask

   task automatic wait_drained();
      wait (pending_events.size() == 0 && expected_reports.size() == 0 && !req_tvalid);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic gesture_event_t make_event(logic [3:0] kind, logic canc, logic [2:0] f,
                                                 logic [31:0] ts, logic [15:0] dx,
                                                 logic [15:0] dy, logic [15:0] scale);
      gesture_event_t e;
      e.kind = kind; e.canc = canc; e.fingers = f; e.ts = ts;
      e.dx = dx; e.dy = dy; e.scale = scale;
      return e;
   endfunction

   function automatic gesture_event_t noise_event();
      return make_event($urandom_range(0, 15), $urandom_range(0, 1), $urandom_range(0, 7),
                        $urandom, $urandom, $urandom, $urandom);
   endfunction

   task automatic push_sequence(inout logic [31:0] ts, input int finger_span, inout int count);
      int g, n;
      logic [2:0] f;
      logic [15:0] dx, dy, sc;
      logic [3:0] kb;
      g = $urandom_range(0, 2);
      kb = g == 0 ? EV_HOLD_BEGIN : (g == 1 ? EV_PINCH_BEGIN : EV_SWIPE_BEGIN);
      f = $urandom_range(0, 9) == 0 ? $urandom_range(0, 7) : $urandom_range(0, finger_span);
      n = g == 0 ? 0 : $urandom_range(0, 10);
      ts += $urandom_range(0, 300);
      pending_events.push_back(make_event(kb, $urandom_range(0, 1), f, ts, $urandom,
                                          $urandom, $urandom));
      count++;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 12) == 0) begin
            pending_events.push_back(noise_event());
            count++;
         end
         ts += $urandom_range(0, 5) == 0 ? $urandom_range(0, 3000) : $urandom_range(0, 120);
         if ($urandom_range(0, 7) == 0) begin
            dx = $urandom;
            dy = $urandom;
         end else begin
            dx = $urandom_range(0, 4096) - 2048;
            dy = $urandom_range(0, 4096) - 2048;
         end
         case ($urandom_range(0, 5))
            0: sc = $urandom;
            1: sc = $urandom_range(0, 3);
            default: sc = $urandom_range(64, 1024);
         endcase
         pending_events.push_back(make_event(4'(kb + 4'd1), $urandom_range(0, 1), f, ts,
                                             dx, dy, sc));
         count++;
      end
      ts += $urandom_range(0, 400);
      if ($urandom_range(0, 7) != 0)
         pending_events.push_back(make_event(g == 0 ? 4'(kb + 4'd1) : 4'(kb + 4'd2),
                                             $urandom_range(0, 9) == 0,
                                             f, ts, $urandom, $urandom, $urandom));
      else
         pending_events.push_back(noise_event());
      count++;
   endtask

   task automatic push_saturating_swipe(inout logic [31:0] ts, input logic [15:0] dx);
      pending_events.push_back(make_event(EV_SWIPE_BEGIN, 0, 0, ts, 0, 0, 0));
      for (int i = 0; i < 260; i++) begin
         ts += 1;
         pending_events.push_back(make_event(EV_SWIPE_UPDATE, 0, 0, ts, dx, ~dx, 256));
      end
      pending_events.push_back(make_event(EV_SWIPE_END, 0, 0, ts, 0, 0, 0));
   endtask

   initial begin
      logic [31:0] ts;
      int count, span;
      logic [4:0] counts[5];
      go_idle();
      m_addr = 0;
      m_count = 0;
      foreach (m_table[i]) m_table[i] = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Extreme words first, then overwritten by the table load.
      csr_write(CSR_ADDR, 4'd15);
      csr_write(CSR_WORD, {58{1'b1}});
      csr_write(CSR_WORD, '0);
      load_table(1, 5'd16);

      ts = 0;
      pending_events.push_back(make_event(EV_SWIPE_BEGIN, 0, 0, 0, 0, 0, 0));
      pending_events.push_back(make_event(EV_SWIPE_BEGIN, 1, 0, 0, 0, 0, 0));
      pending_events.push_back(make_event(EV_SWIPE_UPDATE, 0, 0, 10, 16'h7FFF, 16'h8000, 0));
      pending_events.push_back(make_event(EV_SWIPE_UPDATE, 0, 0, 20, 16'h8000, 16'h7FFF, 0));
      pending_events.push_back(make_event(EV_SWIPE_UPDATE, 0, 7, 30, 0, 0, 16'hFFFF));
      pending_events.push_back(make_event(EV_PINCH_UPDATE, 0, 0, 40, 0, 0, 256));
      pending_events.push_back(make_event(EV_SWIPE_END, 0, 0, 50, 0, 0, 0));
      pending_events.push_back(make_event(EV_SWIPE_END, 0, 0, 60, 0, 0, 0));
      pending_events.push_back(make_event(EV_HOLD_END, 1, 0, 61, 0, 0, 0));
      pending_events.push_back(make_event(EV_PINCH_BEGIN, 0, 1, 70, 0, 0, 0));
      pending_events.push_back(make_event(EV_PINCH_UPDATE, 0, 1, 80, 0, 0, 0));
      pending_events.push_back(make_event(EV_PINCH_UPDATE, 0, 1, 90, 0, 0, 16'hFFFF));
      pending_events.push_back(make_event(EV_PINCH_UPDATE, 0, 1, 95, 0, 0, 512));
      pending_events.push_back(make_event(EV_PINCH_END, 0, 1, 100, 0, 0, 0));
      pending_events.push_back(make_event(EV_HOLD_BEGIN, 0, 1, 32'hFFFF_FFF0, 0, 0, 0));
      pending_events.push_back(make_event(EV_HOLD_BEGIN, 0, 0, 32'hFFFF_FFFF, 0, 0, 0));
      pending_events.push_back(make_event(EV_HOLD_END, 0, 0, 32'h10, 0, 0, 0));
      pending_events.push_back(make_event(EV_PINCH_BEGIN, 0, 0, 5, 0, 0, 0));
      pending_events.push_back(make_event(EV_PINCH_END, 1, 0, 6, 0, 0, 0));
      pending_events.push_back(make_event(EV_OTHER, 0, 0, 7, 0, 0, 0));
      pending_events.push_back(make_event(4'd15, 1, 7, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                                          16'hFFFF));
      wait_drained();

      counts[0] = 5'd16;
      counts[1] = 5'd0;
      counts[2] = 5'd31;
      counts[3] = $urandom_range(1, 15);
      counts[4] = 5'd17;
      for (int p = 0; p < 5; p++) begin
         span = p == 1 ? 7 : $urandom_range(0, 2);
         if (p != 0) load_table(span, counts[p]);
         ts = p == 2 ? 32'hFFFF_F000 : $urandom;
         if (p == 0) push_saturating_swipe(ts, 16'h7FFF);
         if (p == 4) push_saturating_swipe(ts, 16'h8000);
         count = 0;
         while (count < 260) push_sequence(ts, span, count);
         wait_drained();
      end

      $display("Checked %0d reports over five table settings, %0d of them fired a trigger.",
               rsp_count, fired_count);
      $display("Mismatches: %0d.", errors);
      if (errors == 0 && expected_reports.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
